/* hw/rtl/erdd_pkg.sv */
`timescale 1ns / 1ps

package erdd_pkg;

	localparam logic [7:0] ESC_BYTE    = 8'h07;
	localparam logic [7:0] ESC_LITERAL = 8'h00;

	localparam int CFG_IDX_W = 8;

	localparam logic [CFG_IDX_W-1:0] CFG_DICT_LOW  = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DICT_HIGH = 8'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_OUT_LIMIT = 8'd2;

	// One unit of work for the back part: a byte value written reps times.
	typedef struct packed {
		logic [7:0] value;
		logic [3:0] reps;
		logic       last;
	} cmd_t;

	function automatic logic [7:0] dict_entry(input logic [63:0] lo, input logic [63:0] hi,
			input logic [3:0] idx);
		logic [63:0] word;
		word = idx[3] ? hi : lo;
		return word[{idx[2:0], 3'b000} +: 8];
	endfunction

endpackage

/* hw/rtl/erdd_in_if.sv */
`timescale 1ns / 1ps

interface erdd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

/* hw/rtl/erdd_out_if.sv */
`timescale 1ns / 1ps

interface erdd_out_if;
	logic        valid;
	logic        ready;
	logic [7:0]  out_byte;
	logic        has_data;
	logic        run_last;
	logic [31:0] total_written;

	modport source (output valid, output out_byte, output has_data, output run_last,
		output total_written, input ready);
	modport sink (input valid, input out_byte, input has_data, input run_last,
		input total_written, output ready);
endinterface

/* hw/rtl/erdd_cfg_if.sv */
`timescale 1ns / 1ps

interface erdd_cfg_if import erdd_pkg::*;;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [63:0]          data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

/* hw/rtl/erdd_queue.sv */
`timescale 1ns / 1ps

module erdd_queue import erdd_pkg::*; #(
	parameter int DEPTH = 2
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_data,
	output logic full,
	input  logic pop,
	output cmd_t pop_data,
	output logic not_empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	cmd_t          mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] fill_q;

	function automatic logic [AW-1:0] next_ptr(input logic [AW-1:0] p);
		return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
	endfunction

	assign full      = (fill_q == CW'(DEPTH));
	assign not_empty = (fill_q != '0);
	assign pop_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				fill_q <= fill_q + CW'(1);
			end else if (pop && !push) begin
				fill_q <= fill_q - CW'(1);
			end
		end
	end

endmodule

/* hw/rtl/erdd_front.sv */
`timescale 1ns / 1ps

module erdd_front import erdd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	erdd_in_if.sink     in_ch,
	input  logic [63:0] dict_lo,
	input  logic [63:0] dict_hi,
	input  logic        full,
	output logic        push,
	output cmd_t        cmd
);

	logic escape_pending_q;
	logic pending_d;
	logic accept;

	assign in_ch.ready = !full;
	assign accept      = in_ch.valid && in_ch.ready;

	always_comb begin
		cmd.value = in_ch.data_byte;
		cmd.reps  = 4'd1;
		cmd.last  = in_ch.last_byte;
		pending_d = escape_pending_q;
		if (escape_pending_q) begin
			pending_d = 1'b0;
			if (in_ch.data_byte == ESC_LITERAL) begin
				cmd.value = ESC_BYTE;
			end else begin
				cmd.reps  = in_ch.data_byte[7:4];
				cmd.value = dict_entry(dict_lo, dict_hi, in_ch.data_byte[3:0]);
			end
		end else if (in_ch.data_byte == ESC_BYTE && !in_ch.last_byte) begin
			cmd.reps  = 4'd0;
			pending_d = 1'b1;
		end
		if (in_ch.last_byte) begin
			pending_d = 1'b0;
		end
	end

	// Items that write nothing and close no stream need no work at the back.
	assign push = accept && (cmd.reps != 4'd0 || cmd.last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			escape_pending_q <= 1'b0;
		end else if (accept) begin
			escape_pending_q <= pending_d;
		end
	end

endmodule

/* hw/rtl/erdd_back.sv */
`timescale 1ns / 1ps

module erdd_back import erdd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	input  logic        cmd_valid,
	output logic        cmd_pop,
	input  logic [31:0] limit,
	erdd_out_if.source  out_ch
);

	logic        active_q;
	cmd_t        cur_q;
	logic [31:0] count_q;
	logic        out_valid_q;
	logic [7:0]  out_byte_q;
	logic        has_data_q;
	logic        run_last_q;
	logic [31:0] total_q;

	logic        slot_free;
	logic        step;
	logic        blocked;
	logic [32:0] count_inc;
	logic        cut;
	logic        emit_byte;
	logic        emit_end;
	logic        finish;

	assign slot_free = !out_valid_q || out_ch.ready;
	assign step      = active_q && slot_free;
	assign blocked   = (count_q >= limit) || (cur_q.reps == 4'd0);
	assign count_inc = {1'b0, count_q} + 33'd1;
	assign cut       = (count_inc >= {1'b0, limit});
	assign emit_byte = step && !blocked;
	assign emit_end  = step && blocked && cur_q.last;
	assign finish    = step && (blocked || cur_q.reps == 4'd1 || cut);
	assign cmd_pop   = cmd_valid && (!active_q || finish);

	assign out_ch.valid         = out_valid_q;
	assign out_ch.out_byte      = out_byte_q;
	assign out_ch.has_data      = has_data_q;
	assign out_ch.run_last      = run_last_q;
	assign out_ch.total_written = total_q;

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cur_q <= cmd;
		end else if (emit_byte) begin
			cur_q.reps <= cur_q.reps - 4'd1;
		end
		if (emit_byte) begin
			out_byte_q <= cur_q.value;
			has_data_q <= 1'b1;
			run_last_q <= (cur_q.reps == 4'd1) || cut;
			total_q    <= count_inc[31:0];
		end else if (emit_end) begin
			out_byte_q <= 8'h00;
			has_data_q <= 1'b0;
			run_last_q <= 1'b1;
			total_q    <= count_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd_pop) begin
				active_q <= 1'b1;
			end else if (finish) begin
				active_q <= 1'b0;
			end
			if (finish && cur_q.last) begin
				count_q <= '0;
			end else if (emit_byte) begin
				count_q <= count_inc[31:0];
			end
			if (emit_byte || emit_end) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

/* hw/rtl/escape_run_dictionary_decompress_core.sv */
`timescale 1ns / 1ps

// Escape-coded run-length decoder with a sixteen-entry byte dictionary.
// The in_ch channel takes one compressed byte per item with a mark for the
// final byte of a stream. The out_ch channel gives one decompressed byte per
// item, with a flag for the last item that an input item causes and the
// running count of bytes written in the stream; a final byte that writes
// nothing gives one end report item with has_data low.
// The cfg channel writes the two dictionary words and the output limit and is
// always ready; the user must write it only while the block is idle (unchecked).
// A front stage classifies each byte and looks up the dictionary, a command
// queue of QUEUE_DEPTH entries follows, and a back stage writes the bytes.
// Items pass through the queue and the back command register to the output
// register. Literal bytes sustain one item per cycle while out_ch is ready; a
// run holds the back stage until its bytes are written, and input is taken
// until the queue fills. When the receiver stalls, the output register holds
// its item and the queue absorbs up to QUEUE_DEPTH more commands before input stalls.
// Reset clears the configuration, the escape state, the byte count and the queue.
module escape_run_dictionary_decompress_core import erdd_pkg::*; #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic       clk,
	input  logic       arst_n,
	erdd_in_if.sink    in_ch,
	erdd_out_if.source out_ch,
	erdd_cfg_if.sink   cfg
);

	logic [63:0] dict_lo_q;
	logic [63:0] dict_hi_q;
	logic [31:0] limit_q;

	cmd_t push_cmd;
	cmd_t pop_cmd;
	logic push;
	logic pop;
	logic full;
	logic not_empty;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dict_lo_q <= '0;
			dict_hi_q <= '0;
			limit_q   <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_DICT_LOW:  dict_lo_q <= cfg.data;
				CFG_DICT_HIGH: dict_hi_q <= cfg.data;
				CFG_OUT_LIMIT: limit_q   <= cfg.data[31:0];
				default:       ;
			endcase
		end
	end

	erdd_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.dict_lo (dict_lo_q),
		.dict_hi (dict_hi_q),
		.full    (full),
		.push    (push),
		.cmd     (push_cmd)
	);

	erdd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_cmd),
		.full      (full),
		.pop       (pop),
		.pop_data  (pop_cmd),
		.not_empty (not_empty)
	);

	erdd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (pop_cmd),
		.cmd_valid (not_empty),
		.cmd_pop   (pop),
		.limit     (limit_q),
		.out_ch    (out_ch)
	);

	a_within_limit: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.has_data |-> out_ch.total_written <= limit_q)
		else $error("written byte beyond the output limit");

	a_more_follows: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.has_data && !out_ch.run_last
		|-> out_ch.total_written < limit_q)
		else $error("run continues although the limit is reached");

	a_end_report: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.has_data |-> out_ch.run_last && out_ch.out_byte == 8'h00)
		else $error("malformed end report");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full && !pop |-> !push)
		else $error("command queue overflow");

endmodule
